### rtl/sat_pkg.sv
// Package: shared constants, codes and types for the shift array table.
`timescale 1ns / 1ps
`default_nettype none
package sat_pkg;

  localparam int DEPTH  = 128;
  localparam int IDX_W  = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 8;
  localparam int WORD_W = 32;

  // cells are reduced in groups of GRP, then across groups
  localparam int GRP    = 8;
  localparam int GRP_W  = $clog2(GRP);
  localparam int NGRP   = (DEPTH + GRP - 1) / GRP;
  localparam int GSEL_W = (NGRP > 1) ? $clog2(NGRP) : 1;

  // request kinds
  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_APPEND = 3'd1;
  localparam logic [2:0] KIND_DELETE = 3'd2;
  localparam logic [2:0] KIND_SEARCH = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_INS,
    MODE_DEL
  } cell_mode_t;

  // broadcast to every cell
  typedef struct packed {
    cell_mode_t         mode;
    logic [CMP_W-1:0]   idx;
    logic [CMP_W-1:0]   cnt;
    word_t              value;
  } cell_cmd_t;

  // registered summary of one group of cells
  typedef struct packed {
    logic               hit;
    logic [GRP_W-1:0]   lidx;
    word_t              rdata;
  } grp_res_t;

endpackage
`default_nettype wire

### rtl/sat_cell.sv
// One storage cell of the table: holds one word, shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module sat_cell import sat_pkg::*; (
  input  wire logic             clk,
  input  wire logic [IDX_W-1:0] pos,
  input  wire cell_cmd_t        cmd,
  input  wire word_t            left_data,
  input  wire word_t            right_data,
  output word_t                 data,
  output logic                  match,
  output word_t                 rd_data
);

  word_t            data_r;
  word_t            data_nxt;
  logic [CMP_W-1:0] pos_w;

  assign pos_w = CMP_W'(pos);

  always_comb begin
    data_nxt = data_r;
    case (cmd.mode)
      MODE_INS: begin
        if (pos_w > cmd.idx) begin
          data_nxt = left_data;
        end else if (pos_w == cmd.idx) begin
          data_nxt = cmd.value;
        end
      end
      MODE_DEL: begin
        if (pos_w >= cmd.idx) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  // only occupied cells take part in a search
  assign match   = (pos_w < cmd.cnt) && (data_r == cmd.value);
  assign rd_data = data_r & {WORD_W{pos_w == cmd.idx}};

endmodule
`default_nettype wire

### rtl/sat_group.sv
// Registered first-match and read-data reduction over one group of cells.
`timescale 1ns / 1ps
`default_nettype none
module sat_group import sat_pkg::*; (
  input  wire logic           clk,
  input  wire logic [GRP-1:0] match,
  input  wire word_t          rdata [GRP],
  output grp_res_t            res
);

  grp_res_t res_r;
  grp_res_t res_nxt;

  always_comb begin
    res_nxt.hit   = |match;
    res_nxt.lidx  = '0;
    res_nxt.rdata = '0;
    for (int k = GRP - 1; k >= 0; k--) begin
      if (match[k]) begin
        res_nxt.lidx = GRP_W'(k);
      end
      res_nxt.rdata = res_nxt.rdata | rdata[k];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule
`default_nettype wire

### rtl/shift_array_table.sv
// Top level: packed table of signed words with insert, append, delete, search, read.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------------
//  request  | start / busy              | in_kind, in_value, in_index
//  result   | out_valid (1-cycle pulse) | out_status, out_found_index, out_read_value,
//           |                           | out_fill_count
//
// A request transaction is taken at an edge with start high and busy low. Every
// request yields one result transaction, through the EXEC state, in which the cell
// chain shifts and compares into the group registers, the REDUCE state, in which
// the cross-group reduce loads the output registers, and the cycle that shows it.
// busy is high in the EXEC and REDUCE states; a new request can be taken in the
// cycle the previous result is shown. rst_n (synchronous) clears the count and
// control; cell contents are left as they are. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module shift_array_table import sat_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_kind,
  input  wire logic signed [31:0] in_value,
  input  wire logic [7:0]         in_index,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [6:0]              out_found_index,
  output logic signed [31:0]      out_read_value,
  output logic [7:0]              out_fill_count
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REDUCE
  } state_t;

  state_t           state_r;
  logic [2:0]       kind_r;
  word_t            value_r;
  logic [7:0]       index_r;
  logic [CNT_W-1:0] count_r;
  logic [1:0]       st_r;

  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [6:0]       out_found_r;
  word_t            out_read_r;
  logic [7:0]       out_fill_r;

  // request decode against the current fill count
  logic [CMP_W-1:0] cnt_w;
  logic [CMP_W-1:0] idx_w;
  logic             is_full;
  logic             ins_ok;
  logic             del_ok;
  logic [1:0]       st_nxt;
  cell_cmd_t        cmd;

  assign cnt_w   = CMP_W'(count_r);
  assign idx_w   = CMP_W'(index_r);
  assign is_full = (cnt_w >= CMP_W'(DEPTH));

  always_comb begin
    st_nxt = ST_OK;
    ins_ok = 1'b0;
    del_ok = 1'b0;
    case (kind_r)
      KIND_INSERT: begin
        if (is_full) begin
          st_nxt = ST_FULL;
        end else if (idx_w > cnt_w) begin
          st_nxt = ST_RANGE;
        end else begin
          ins_ok = 1'b1;
        end
      end
      KIND_APPEND: begin
        if (is_full) begin
          st_nxt = ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (idx_w >= cnt_w) begin
          st_nxt = ST_RANGE;
        end else begin
          del_ok = 1'b1;
        end
      end
      KIND_READ: begin
        if (idx_w >= cnt_w) begin
          st_nxt = ST_RANGE;
        end
      end
      default: st_nxt = ST_OK;   // search resolves later; spare kinds do nothing
    endcase
  end

  // broadcast to the cell chain; an append is an insert at the fill count
  always_comb begin
    cmd.mode  = MODE_HOLD;
    cmd.idx   = (kind_r == KIND_APPEND) ? cnt_w : idx_w;
    cmd.cnt   = cnt_w;
    cmd.value = value_r;
    if (state_r == S_EXEC) begin
      if (ins_ok) begin
        cmd.mode = MODE_INS;
      end else if (del_ok) begin
        cmd.mode = MODE_DEL;
      end
    end
  end

  // cell chain
  word_t          cell_data  [DEPTH];
  word_t          cell_rd    [DEPTH];
  logic [DEPTH-1:0] cell_match;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      word_t left_w;
      word_t right_w;
      if (i == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign right_w = cell_data[i];
      end else begin : g_mid_r
        assign right_w = cell_data[i+1];
      end
      sat_cell u_cell (
        .clk        (clk),
        .pos        (IDX_W'(i)),
        .cmd        (cmd),
        .left_data  (left_w),
        .right_data (right_w),
        .data       (cell_data[i]),
        .match      (cell_match[i]),
        .rd_data    (cell_rd[i])
      );
    end
  endgenerate

  // first reduction level, registered per group of cells
  grp_res_t grp_res [NGRP];

  genvar g, k;
  generate
    for (g = 0; g < NGRP; g++) begin : g_grp
      logic [GRP-1:0] gm;
      word_t          gd [GRP];
      for (k = 0; k < GRP; k++) begin : g_tap
        if (g * GRP + k < DEPTH) begin : g_real
          assign gm[k] = cell_match[g*GRP+k];
          assign gd[k] = cell_rd[g*GRP+k];
        end else begin : g_pad
          assign gm[k] = 1'b0;
          assign gd[k] = '0;
        end
      end
      sat_group u_group (
        .clk   (clk),
        .match (gm),
        .rdata (gd),
        .res   (grp_res[g])
      );
    end
  endgenerate

  // final reduction across groups
  logic              any_hit;
  logic [GSEL_W-1:0] gsel;
  logic [GRP_W-1:0]  lsel;
  word_t             rd_or;
  logic [IDX_W-1:0]  found_idx;

  always_comb begin
    any_hit = 1'b0;
    gsel    = '0;
    lsel    = '0;
    rd_or   = '0;
    for (int n = NGRP - 1; n >= 0; n--) begin
      if (grp_res[n].hit) begin
        any_hit = 1'b1;
        gsel    = GSEL_W'(n);
        lsel    = grp_res[n].lidx;
      end
      rd_or = rd_or | grp_res[n].rdata;
    end
  end

  assign found_idx = IDX_W'({gsel, lsel});

  // sequencer, count and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            kind_r  <= in_kind;
            value_r <= in_value;
            index_r <= in_index;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          st_r <= st_nxt;
          if (ins_ok) begin
            count_r <= count_r + CNT_W'(1);
          end else if (del_ok) begin
            count_r <= count_r - CNT_W'(1);
          end
          state_r <= S_REDUCE;
        end
        S_REDUCE: begin
          out_valid_r <= 1'b1;
          out_fill_r  <= 8'(count_r);
          out_found_r <= '0;
          out_read_r  <= '0;
          if (kind_r == KIND_SEARCH) begin
            out_status_r <= any_hit ? ST_OK : ST_NOTFOUND;
            if (any_hit) begin
              out_found_r <= 7'(found_idx);
            end
          end else begin
            out_status_r <= st_r;
            if (kind_r == KIND_READ && st_r == ST_OK) begin
              out_read_r <= rd_or;
            end
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_found_r;
  assign out_read_value  = out_read_r;
  assign out_fill_count  = out_fill_r;

`ifndef SYNTH
  // every accepted transaction yields its result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result not produced three cycles after request");

  // the fill count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CMP_W'(out_fill_count) <= CMP_W'(DEPTH)))
    else $error("fill count beyond depth");

  // a full report only happens on a full table
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (CMP_W'(out_fill_count) == CMP_W'(DEPTH)))
    else $error("full status with room left");

  // a nonzero found index always lies inside the occupied part
  a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found_index != 7'd0) |-> (8'(out_found_index) < out_fill_count))
    else $error("found index outside occupied entries");
`endif

endmodule
`default_nettype wire

### verif/testbench.sv
// Testbench for shift_array_table: directed and random requests checked against a local model.
`timescale 1ns / 1ps
module testbench;
  import sat_pkg::*;

  // No transaction in this many cycles means the block is hung.
  localparam int QUIET_LIMIT = 1000;
  // Extra edges waited after the last reply, to catch stray results.
  localparam int END_SETTLE  = 8;

  // Kinds five to seven are unused and must behave as no-ops.
  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

  typedef struct {
    logic [1:0]         status;
    logic [6:0]         found_index;
    logic signed [31:0] read_value;
    logic [7:0]         fill_count;
  } table_reply_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [2:0]         in_kind;
  logic signed [31:0] in_value;
  logic [7:0]         in_index;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [6:0]         out_found_index;
  logic signed [31:0] out_read_value;
  logic [7:0]         out_fill_count;

  // Local copy of the table contents and fill level.
  word_t        table_words [DEPTH];
  int           table_count = 0;
  // Replies predicted for accepted requests, oldest first.
  table_reply_t replies_due [$];

  int error_count     = 0;
  int quiet_cycles    = 0;
  int sender_idle_pct = 0;
  int requests_taken  = 0;
  int results_checked = 0;
  int peak_fill       = 0;
  int spare_seen      = 0;
  int kind_seen [8];
  int status_seen [4];

  shift_array_table i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .in_index        (in_index),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_read_value  (out_read_value),
    .out_fill_count  (out_fill_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Applies one request to the local table and returns the reply it must give.
  function automatic table_reply_t apply_table_request(input logic [2:0] kind,
                                                       input word_t value,
                                                       input logic [7:0] index);
    table_reply_t reply;
    bit           hit;
    reply.status      = ST_OK;
    reply.found_index = '0;
    reply.read_value  = '0;
    hit               = 1'b0;
    case (kind)
      KIND_INSERT: begin
        // fullness wins over a bad index
        if (table_count >= DEPTH) begin
          reply.status = ST_FULL;
        end else if (index > table_count) begin
          reply.status = ST_RANGE;
        end else begin
          // shift from the top down so nothing is overwritten
          for (int i = table_count; i > index; i--) table_words[i] = table_words[i-1];
          table_words[index] = value;
          table_count++;
        end
      end
      KIND_APPEND: begin
        if (table_count >= DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          table_words[table_count] = value;
          table_count++;
        end
      end
      KIND_DELETE: begin
        if (index >= table_count) begin
          reply.status = ST_RANGE;
        end else begin
          for (int i = index; i + 1 < table_count; i++) table_words[i] = table_words[i+1];
          table_count--;
        end
      end
      KIND_SEARCH: begin
        reply.status = ST_NOTFOUND;
        // first match wins
        for (int i = 0; i < table_count && !hit; i++) begin
          if (table_words[i] == value) begin
            hit               = 1'b1;
            reply.status      = ST_OK;
            reply.found_index = i[6:0];
          end
        end
      end
      KIND_READ: begin
        if (index >= table_count) reply.status = ST_RANGE;
        else reply.read_value = table_words[index];
      end
      default: ;
    endcase
    reply.fill_count = table_count[7:0];
    return reply;
  endfunction

  // Drives one request transaction, with random idle cycles ahead of it, and
  // returns at the edge that takes it. The reply is predicted right there, so
  // the local table is current for whatever the caller picks next.
  task automatic send_request(input logic [2:0] kind, input word_t value,
                              input logic [7:0] index);
    table_reply_t reply;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    in_index <= index;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    reply = apply_table_request(kind, value, index);
    replies_due.push_back(reply);
    requests_taken++;
    status_seen[reply.status]++;
    if (kind >= KIND_SPARE_FIRST) spare_seen++;
    else kind_seen[kind]++;
    if (table_count > peak_fill) peak_fill = table_count;
  endtask

  // Holds off new requests until every outstanding reply is back.
  // Always spends at least one edge with start low.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  // Empty table: searches, reads, deletes and inserts past the end all fail,
  // and the spare kinds do nothing even with every value and index bit set.
  task automatic test_empty_table();
    send_request(KIND_SEARCH, 32'h0000_0000, 8'd0);
    send_request(KIND_READ,   32'h0000_0000, 8'd0);
    send_request(KIND_DELETE, 32'h0000_0000, 8'd0);
    send_request(KIND_INSERT, 32'h0000_0007, 8'd1);
    send_request(KIND_READ,   32'hFFFF_FFFF, 8'hFF);
    for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) begin
      send_request(3'(k), 32'hFFFF_FFFF, 8'hFF);
    end
  endtask

  // Basic edits on a short table, with the word extremes as payload.
  task automatic test_edit_ops();
    send_request(KIND_INSERT, 32'h8000_0000, 8'd0);
    send_request(KIND_APPEND, 32'h7FFF_FFFF, 8'd0);
    send_request(KIND_INSERT, 32'hFFFF_FFFF, 8'd1);   // middle insert shifts one up
    send_request(KIND_INSERT, 32'h0000_0000, 8'd3);   // index == count acts as append
    send_request(KIND_INSERT, 32'h0000_0001, 8'd5);   // past the end
    for (int i = 0; i < 4; i++) send_request(KIND_READ, 32'h0, 8'(i));
    send_request(KIND_SEARCH, 32'hFFFF_FFFF, 8'd0);
    send_request(KIND_SEARCH, 32'h0000_0000, 8'd0);
    send_request(KIND_SEARCH, 32'h1234_5678, 8'd0);   // no match
    send_request(KIND_DELETE, 32'h0, 8'd1);
    send_request(KIND_READ,   32'h0, 8'd1);
    send_request(KIND_DELETE, 32'h0, 8'd3);           // index == count
    send_request(KIND_READ,   32'h0, 8'd3);
  endtask

  // Fill to the brim, probe the full cases, then empty it again.
  task automatic test_full_table();
    sender_idle_pct = 11;
    while (table_count < DEPTH) begin
      // small values now and then so searches meet duplicates
      send_request(KIND_APPEND, ($urandom_range(3) == 0) ? 32'($urandom_range(7)) : $urandom,
                   8'($urandom_range(255)));
    end
    send_request(KIND_APPEND, $urandom, 8'd0);
    send_request(KIND_INSERT, $urandom, 8'd200);      // full is reported before range
    send_request(KIND_INSERT, $urandom, 8'd0);
    send_request(KIND_SEARCH, table_words[DEPTH-1], 8'd0);
    send_request(KIND_READ,   32'h0, 8'(DEPTH - 1));
    send_request(KIND_READ,   32'h0, 8'(DEPTH));
    send_request(KIND_DELETE, 32'h0, 8'(DEPTH - 1));
    send_request(KIND_INSERT, $urandom, 8'd0);        // full again, every entry moved
    send_request(KIND_DELETE, 32'h0, 8'd0);           // every entry moves back down
    send_request(KIND_READ,   32'h0, 8'(DEPTH - 2));
    send_request(KIND_READ,   32'h0, 8'(DEPTH - 1));
    while (table_count > 0) begin
      send_request(KIND_DELETE, $urandom, 8'($urandom_range(table_count - 1)));
    end
  endtask

  // Random traffic. The mix swings between growing and shrinking so the fill
  // level sweeps the whole range; most indexes are in range, searches often
  // target a word that is present.
  task automatic run_random_mix(input int n_requests, input int idle_pct);
    logic [2:0] kind;
    word_t      value;
    logic [7:0] index;
    int         roll;
    bit         grow;
    sender_idle_pct = idle_pct;
    grow            = 1'b1;
    for (int n = 0; n < n_requests; n++) begin
      if (table_count == DEPTH) grow = 1'b0;
      else if (table_count == 0) grow = 1'b1;
      else if ($urandom_range(39) == 0) grow = !grow;

      roll = $urandom_range(99);
      if (roll < 5) kind = 3'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
      else if (roll < (grow ? 35 : 15)) kind = KIND_INSERT;
      else if (roll < (grow ? 55 : 25)) kind = KIND_APPEND;
      else if (roll < 65) kind = KIND_DELETE;
      else if (roll < 83) kind = KIND_SEARCH;
      else kind = KIND_READ;

      roll = $urandom_range(9);
      if (roll < 7) index = 8'($urandom_range(table_count));
      else if (roll == 7) index = 8'(table_count);
      else index = 8'($urandom_range(255));

      roll = $urandom_range(3);
      if (roll == 0) value = 32'($urandom_range(4)) - 32'd2;
      else if (roll == 1 && table_count > 0) value = table_words[$urandom_range(table_count - 1)];
      else value = $urandom;

      if ($urandom_range(149) == 0) wait_drained();
      send_request(kind, value, index);
    end
  endtask

  // Result checker: every result transaction is matched against the oldest
  // prediction. Also tracks how long the interface has been quiet.
  always @(posedge clk) begin : result_check
    table_reply_t want;
    if (rst_n) begin
      quiet_cycles = quiet_cycles + 1;
      if (start && busy === 1'b0) quiet_cycles = 0;
      if (out_valid === 1'b1) begin
        quiet_cycles = 0;
        results_checked++;
        if (replies_due.size() == 0) begin
          $error("result transaction with no request outstanding");
          error_count++;
        end else begin
          want = replies_due.pop_front();
          if (out_status !== want.status) begin
            $error("out_status: expected %0d, actual %0d", want.status, out_status);
            error_count++;
          end
          if (out_found_index !== want.found_index) begin
            $error("out_found_index: expected %0d, actual %0d",
                   want.found_index, out_found_index);
            error_count++;
          end
          if (out_read_value !== want.read_value) begin
            $error("out_read_value: expected %0d, actual %0d",
                   want.read_value, out_read_value);
            error_count++;
          end
          if (out_fill_count !== want.fill_count) begin
            $error("out_fill_count: expected %0d, actual %0d",
                   want.fill_count, out_fill_count);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: ends the run if neither side moves for too long.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $error("timeout: no transaction for %0d cycles", QUIET_LIMIT);
    $display("shift_array_table test failed");
    $finish;
  end

  initial begin
    int guard;
    start    = 1'b0;
    in_kind  = KIND_INSERT;
    in_value = '0;
    in_index = '0;
    rst_n    = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 11;
    test_empty_table();
    test_edit_ops();
    wait_drained();
    test_full_table();
    wait_drained();

    // sparse gaps, then mostly idle sender, then back to back
    run_random_mix(290, 11);
    wait_drained();
    run_random_mix(290, 72);
    wait_drained();
    run_random_mix(290, 0);

    start <= 1'b0;
    guard = 0;
    while (replies_due.size() != 0 && guard < QUIET_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (END_SETTLE) @(posedge clk);
    if (replies_due.size() != 0) begin
      $error("%0d predicted results never arrived", replies_due.size());
      error_count += replies_due.size();
    end

    $display("Ran %0d: ins %0d, app %0d, del %0d, srch %0d, rd %0d, spare %0d; peak fill %0d",
             requests_taken, kind_seen[KIND_INSERT], kind_seen[KIND_APPEND],
             kind_seen[KIND_DELETE], kind_seen[KIND_SEARCH], kind_seen[KIND_READ],
             spare_seen, peak_fill);
    $display("Statuses: ok %0d, full %0d, out of range %0d, not found %0d; %0d results checked",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_RANGE],
             status_seen[ST_NOTFOUND], results_checked);
    if (error_count == 0) begin
      $display("shift_array_table test passed");
    end else begin
      $display("shift_array_table test failed");
    end
    $finish;
  end

endmodule

### shift_array_table.f
rtl/sat_pkg.sv
rtl/sat_cell.sv
rtl/sat_group.sv
rtl/shift_array_table.sv
verif/testbench.sv
